// File: rtl/ptb_pkg.sv
// Shared types and constants for the periodic timer bank.
package ptb_pkg;

	// Fixed field widths of the stream words.
	localparam int OPCODE_W    = 3;
	localparam int CHANNEL_W   = 8;
	localparam int PERIOD_W    = 32;
	localparam int SLOT_W      = 4;
	localparam int MASK_W      = 16;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	// Operation codes carried in the input tuser.
	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK    = 3'd0,
		OP_ALLOC   = 3'd1,
		OP_ENABLE  = 3'd2,
		OP_DISABLE = 3'd3,
		OP_UPDATE  = 3'd4
	} opcode_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
	} ptb_cmd_t;

endpackage

// File: rtl/ptb_ctrl.sv
// Controller state machine: input handshake, execute strobe and output valid.
module ptb_ctrl
	import ptb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output ptb_cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands. An item executes once the output register is free
	// or is being emptied in the same cycle.
	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_valid_q || out_ready) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: rtl/ptb_datapath.sv
// Datapath: captured operation, counter lanes, enables, allocator and result word.
module ptb_datapath
	import ptb_pkg::*;
#(
	parameter int NUM_TIMERS  = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptb_cmd_t               cmd,
	input  logic [OPCODE_W-1:0]    in_opcode,
	input  logic [CHANNEL_W-1:0]   in_channel,
	input  logic [PERIOD_W-1:0]    in_period,
	input  logic                   in_has_handler,
	output logic [OUT_TDATA_W-1:0] result
);

	localparam int ALLOC_W = $clog2(NUM_TIMERS + 1);
	localparam logic [ALLOC_W-1:0] ALLOC_MAX = ALLOC_W'(NUM_TIMERS);

	opcode_t                op_q;
	logic [CHANNEL_W-1:0]   ch_q;
	logic [COUNT_WIDTH-1:0] per_q;
	logic                   hh_q;

	logic [COUNT_WIDTH-1:0] counter_q [NUM_TIMERS];
	logic [COUNT_WIDTH-1:0] reload_q  [NUM_TIMERS];
	logic [NUM_TIMERS-1:0]  enable_q;
	logic [ALLOC_W-1:0]     alloc_q;
	logic [NUM_TIMERS-1:0]  lane_hit;
	logic [MASK_W-1:0]      tick_mask;
	logic                   alloc_free;
	logic                   alloc_ok;
	logic [OUT_TDATA_W-1:0] result_q;
	logic                   res_status;
	logic [SLOT_W-1:0]      res_slot;
	logic [MASK_W-1:0]      res_mask;

	// Capture of the accepted operation; the period is fitted to the counter width.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode_t'(in_opcode);
			ch_q  <= in_channel;
			per_q <= COUNT_WIDTH'(in_period);
			hh_q  <= in_has_handler;
		end
	end

	assign alloc_free = (alloc_q < ALLOC_MAX);
	assign alloc_ok   = alloc_free && hh_q;

	// One lane per timer: its own decrementer, reload and enable bit.
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_lane
		logic [COUNT_WIDTH-1:0] dec;
		logic                   chan_sel;
		logic                   alloc_sel;

		assign dec       = counter_q[i] - COUNT_WIDTH'(1);
		assign chan_sel  = (ch_q == CHANNEL_W'(i));
		assign alloc_sel = alloc_free && (alloc_q == ALLOC_W'(i));
		assign lane_hit[i] = enable_q[i] && (dec == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				counter_q[i] <= '0;
				reload_q[i]  <= '0;
				enable_q[i]  <= 1'b0;
			end else if (cmd.exec) begin
				case (op_q)
					OP_TICK: begin
						if (enable_q[i]) begin
							counter_q[i] <= lane_hit[i] ? reload_q[i] : dec;
						end
					end
					OP_ALLOC: begin
						if (alloc_sel) begin
							counter_q[i] <= per_q;
							reload_q[i]  <= per_q;
						end
					end
					OP_ENABLE: begin
						if (chan_sel) begin
							enable_q[i] <= 1'b1;
						end
					end
					OP_DISABLE: begin
						if (chan_sel) begin
							enable_q[i] <= 1'b0;
						end
					end
					OP_UPDATE: begin
						if (chan_sel) begin
							counter_q[i] <= per_q;
							reload_q[i]  <= per_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Only the first sixteen lanes have a bit in the expiry mask.
	for (genvar k = 0; k < MASK_W; k++) begin : g_mask
		if (k < NUM_TIMERS) begin : g_used
			assign tick_mask[k] = lane_hit[k];
		end else begin : g_unused
			assign tick_mask[k] = 1'b0;
		end
	end

	// Allocation count advances only when a handler is attached.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q <= '0;
		end else if (cmd.exec && (op_q == OP_ALLOC) && alloc_ok) begin
			alloc_q <= alloc_q + ALLOC_W'(1);
		end
	end

	// Result fields for the operation in hand.
	always_comb begin
		res_status = 1'b0;
		res_slot   = '0;
		res_mask   = '0;
		case (op_q)
			OP_TICK: begin
				res_mask = tick_mask;
			end
			OP_ALLOC: begin
				res_status = !alloc_ok;
				if (alloc_ok) begin
					res_slot = SLOT_W'(alloc_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_q <= OUT_TDATA_W'({res_mask, res_slot, res_status});
		end
	end

	assign result = result_q;

endmodule

// File: rtl/periodic_timer_bank_top.sv
// Top level of the periodic timer bank: controller, datapath and checks.
//
//  Channel  | Dir | Signals                                | Payload
//  ---------+-----+----------------------------------------+------------------------------
//  s_axis   | in  | s_axis_tvalid/tready/tdata/tuser       | one operation word
//  m_axis   | out | m_axis_tvalid/tready/tdata             | one result word per operation
//
// Every operation is first accepted and its word captured, then executed on
// all timer lanes at once, which loads the output register.
// A tick runs one decrementer per lane in parallel, so it costs the same as any other operation.
// Execution waits while the output register still holds a word not taken downstream.
// Reset clears all counters, reloads, enable bits and the allocation count.
module periodic_timer_bank_top
	import ptb_pkg::*;
#(
	parameter int NUM_TIMERS  = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// Fields from bit 0: channel[7:0], period[39:8], has_handler[40], zero fill.
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// Fields from bit 0: opcode[2:0].
	input  logic [OPCODE_W-1:0]    s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// Fields from bit 0: status[0], slot[4:1], expired_mask[20:5], zero fill.
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	ptb_cmd_t cmd;

	// Sequencing of the handshakes.
	ptb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// Timer lanes and result word.
	ptb_datapath #(
		.NUM_TIMERS  (NUM_TIMERS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_opcode      (s_axis_tuser),
		.in_channel     (s_axis_tdata[CHANNEL_W-1:0]),
		.in_period      (s_axis_tdata[CHANNEL_W+PERIOD_W-1:CHANNEL_W]),
		.in_has_handler (s_axis_tdata[CHANNEL_W+PERIOD_W]),
		.result         (m_axis_tdata)
	);

	// An executed operation always leaves a word on the output.
	a_exec_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> m_axis_tvalid)
		else $error("executed operation produced no output word");

	// Input is never taken while an operation is executing.
	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && cmd.exec))
		else $error("input ready while executing");

	// A failed allocation reports neither a slot nor expiries.
	a_fail_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[0]) |->
			(m_axis_tdata[OUT_TDATA_W-1:1] == '0))
		else $error("failed allocation carries nonzero fields");

endmodule
